// ===== rtl/core/haptic_ratchet_torque_macros.svh =====
// Assertion macros shared by the haptic ratchet torque block.
`ifndef HAPTIC_RATCHET_TORQUE_MACROS_SVH
`define HAPTIC_RATCHET_TORQUE_MACROS_SVH

// An implication that is checked at every rising clock edge outside reset.
`define HRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("haptic ratchet torque: implication check failed");

// A condition that holds at every rising clock edge outside reset.
`define HRT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("haptic ratchet torque: invariant check failed");

`endif

// ===== rtl/core/hrt_pkg.sv =====
// Types and constants shared by the haptic ratchet torque modules.
package hrt_pkg;

  localparam int          DEAD_ZONE     = 1311;
  localparam int          SPRING_OFFSET = 655;

  localparam logic [25:0] CREEP_RECIP = 26'd36028797;
  localparam int unsigned CREEP_SHIFT = 40;
  localparam logic [22:0] CREEP_DIV   = 23'd1953125;

  typedef enum logic [1:0] {
    CFG_RATE_MAX  = 2'd0,
    CFG_GATE_THR  = 2'd1,
    CFG_GATE_GAP  = 2'd2
  } hrt_cfg_idx_e;

  typedef struct packed {
    logic        [13:0] rate_max_mv;
    logic signed [14:0] gate_threshold_mv;
    logic        [12:0] gate_half_gap_mv;
  } hrt_cfg_t;

  typedef struct packed {
    logic signed [31:0] knob_angle;
    logic signed [14:0] rate_mv;
    logic        [15:0] tick_us;
    logic               forward;
  } hrt_pre_t;

  typedef struct packed {
    logic signed [31:0] knob_angle;
    logic        [15:0] creep;
    logic               forward;
  } hrt_mid_t;

endpackage

// ===== rtl/core/hrt_dir.sv =====
// Gate hysteresis and ratchet direction state.
module hrt_dir (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  hrt_pkg::hrt_cfg_t   cfg,
  input  logic signed [14:0]  gate_mv,
  input  logic                gate_plugged,
  input  logic                flip_direction,
  output logic                forward
);
  import hrt_pkg::*;

  logic               fwd_r;
  logic               gate_r;
  logic               gate_nxt;
  logic               fwd_flip;
  logic signed [16:0] band_hi;
  logic signed [16:0] band_lo;
  logic signed [16:0] gate_x;

  always_comb begin
    band_hi  = 17'(cfg.gate_threshold_mv) + $signed({4'b0, cfg.gate_half_gap_mv});
    band_lo  = 17'(cfg.gate_threshold_mv) - $signed({4'b0, cfg.gate_half_gap_mv});
    gate_x   = 17'(gate_mv);
    fwd_flip = flip_direction ? !fwd_r : fwd_r;
    gate_nxt = gate_r;
    if (!gate_r && (gate_x > band_hi)) begin
      gate_nxt = 1'b1;
    end else if (gate_r && (gate_x < band_lo)) begin
      gate_nxt = 1'b0;
    end
    forward = gate_plugged ? !gate_nxt : fwd_flip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= 1'b1;
      gate_r <= 1'b0;
    end else if (adv) begin
      fwd_r  <= forward;
      gate_r <= gate_nxt;
    end
  end

endmodule

// ===== rtl/core/hrt_creep.sv =====
// Creep pipeline: rate clamp, rate-time product and division by a constant.
module hrt_creep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [13:0]       rate_max_mv,
  input  logic              in_valid,
  output logic              in_ready,
  input  hrt_pkg::hrt_pre_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output hrt_pkg::hrt_mid_t out_item
);
  import hrt_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic        [13:0] rate_c;
  logic        [29:0] rt_nxt;
  logic        [55:0] q_prod;
  logic        [22:0] plo_nxt;
  logic        [22:0] rem;
  logic        [15:0] creep_nxt;

  logic        [29:0] rt1_r;
  logic signed [31:0] ang1_r;
  logic               fwd1_r;

  logic        [15:0] q2_r;
  logic        [16:0] rt2_r;
  logic signed [31:0] ang2_r;
  logic               fwd2_r;

  logic        [22:0] plo3_r;
  logic        [15:0] q3_r;
  logic        [16:0] rt3_r;
  logic signed [31:0] ang3_r;
  logic               fwd3_r;

  hrt_mid_t           item4_r;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign out_valid = v4_r;
  assign out_item  = item4_r;

  always_comb begin
    if (in_item.rate_mv[14]) begin
      rate_c = 14'd0;
    end else if (in_item.rate_mv[13:0] > rate_max_mv) begin
      rate_c = rate_max_mv;
    end else begin
      rate_c = in_item.rate_mv[13:0];
    end
    rt_nxt    = 30'(rate_c) * 30'(in_item.tick_us);
    q_prod    = 56'(rt1_r) * 56'(CREEP_RECIP);
    plo_nxt   = 23'(q2_r) * CREEP_DIV;
    rem       = {rt3_r, 6'b0} - plo3_r;
    creep_nxt = q3_r + 16'(rem >= CREEP_DIV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      rt1_r  <= rt_nxt;
      ang1_r <= in_item.knob_angle;
      fwd1_r <= in_item.forward;
    end
    if (rdy2 && v1_r) begin
      q2_r   <= q_prod[CREEP_SHIFT +: 16];
      rt2_r  <= rt1_r[16:0];
      ang2_r <= ang1_r;
      fwd2_r <= fwd1_r;
    end
    if (rdy3 && v2_r) begin
      plo3_r <= plo_nxt;
      q3_r   <= q2_r;
      rt3_r  <= rt2_r;
      ang3_r <= ang2_r;
      fwd3_r <= fwd2_r;
    end
    if (rdy4 && v3_r) begin
      item4_r.knob_angle <= ang3_r;
      item4_r.creep      <= creep_nxt;
      item4_r.forward    <= fwd3_r;
    end
  end

endmodule

// ===== rtl/core/hrt_ratchet.sv =====
// Ratchet angle state, spring distance and saturated torque output stage.
module hrt_ratchet (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hrt_pkg::hrt_mid_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_torque,
  output logic signed [31:0] out_position,
  output logic               out_forward
);
  import hrt_pkg::*;

  logic               v5_r, v6_r;
  logic               rdy5, rdy6;
  logic               adv5;

  logic signed [31:0] ratchet_r;
  logic               started_r;

  logic signed [31:0] r_cur;
  logic signed [32:0] a_minus_r;
  logic signed [32:0] r_creep;
  logic signed [31:0] r_sat;
  logic signed [31:0] r_nxt;
  logic signed [33:0] dist_nxt;

  logic signed [31:0] pos5_r;
  logic signed [33:0] dist5_r;
  logic               fwd5_r;

  logic               spring_on;
  logic signed [41:0] dist_x;
  logic signed [41:0] torque_full;
  logic signed [31:0] torque_nxt;

  logic signed [31:0] torque6_r;
  logic signed [31:0] pos6_r;
  logic               fwd6_r;

  assign rdy6     = !v6_r || out_ready;
  assign rdy5     = !v5_r || rdy6;
  assign in_ready = rdy5;
  assign adv5     = in_valid && rdy5;

  assign out_valid    = v6_r;
  assign out_torque   = torque6_r;
  assign out_position = pos6_r;
  assign out_forward  = fwd6_r;

  always_comb begin
    r_cur     = started_r ? ratchet_r : in_item.knob_angle;
    a_minus_r = 33'(in_item.knob_angle) - 33'(r_cur);
    if (in_item.forward) begin
      r_creep = 33'(r_cur) - $signed({17'b0, in_item.creep});
    end else begin
      r_creep = 33'(r_cur) + $signed({17'b0, in_item.creep});
    end
    if (r_creep[32] != r_creep[31]) begin
      r_sat = r_creep[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r_sat = r_creep[31:0];
    end
    r_nxt = r_cur;
    if (in_item.forward) begin
      if (a_minus_r > 33'sd0) begin
        r_nxt = in_item.knob_angle;
      end else if (a_minus_r < -33'(DEAD_ZONE)) begin
        r_nxt = r_sat;
      end
    end else begin
      if (a_minus_r < 33'sd0) begin
        r_nxt = in_item.knob_angle;
      end else if (a_minus_r > 33'(DEAD_ZONE)) begin
        r_nxt = r_sat;
      end
    end
    if (in_item.forward) begin
      dist_nxt = 34'(r_nxt) - 34'(SPRING_OFFSET) - 34'(in_item.knob_angle);
    end else begin
      dist_nxt = 34'(r_nxt) + 34'(SPRING_OFFSET) - 34'(in_item.knob_angle);
    end
  end

  always_comb begin
    spring_on   = fwd5_r ? !dist5_r[33] : (dist5_r[33] || (dist5_r == 34'sd0));
    dist_x      = 42'(dist5_r);
    torque_full = (dist_x <<< 7) + (dist_x <<< 6) + (dist_x <<< 3);
    if (!spring_on) begin
      torque_nxt = 32'sd0;
    end else if (torque_full > 42'sh7FFF_FFFF) begin
      torque_nxt = 32'sh7FFF_FFFF;
    end else if (torque_full < -42'sh8000_0000) begin
      torque_nxt = 32'sh8000_0000;
    end else begin
      torque_nxt = torque_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r      <= 1'b0;
      v6_r      <= 1'b0;
      started_r <= 1'b0;
      ratchet_r <= 32'sd0;
    end else begin
      if (rdy5) begin
        v5_r <= in_valid;
      end
      if (rdy6) begin
        v6_r <= v5_r;
      end
      if (adv5) begin
        started_r <= 1'b1;
        ratchet_r <= r_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      pos5_r  <= r_nxt;
      dist5_r <= dist_nxt;
      fwd5_r  <= in_item.forward;
    end
    if (rdy6 && v5_r) begin
      torque6_r <= torque_nxt;
      pos6_r    <= pos5_r;
      fwd6_r    <= fwd5_r;
    end
  end

endmodule

// ===== rtl/core/haptic_ratchet_torque.sv =====
// Top level of the haptic ratchet torque block.
//
// One request on the in_ channel is one control tick of the knob; every tick
// gives exactly one request on the out_ channel, in the same order. The
// configuration registers are written through cfg_we, cfg_index and
// cfg_wdata, and the user must write them only while no tick is in flight;
// the block does not enforce this. An unknown index is ignored. A tick is
// registered on acceptance and passes through six more register stages before
// its result is shown on out_tvalid. One tick is taken in every cycle when
// nothing stalls: the creep division by a constant and the torque scaling
// are pipelined, and the ratchet angle is updated in a single stage so that
// the next tick sees it at once. Each stage holds its request while the stage
// after it is stalled, so bubbles close up and a stalled out_tready fills
// the pipeline before in_tready falls. Synchronous reset empties the
// pipeline, restores the register defaults, points the ratchet forward with
// the gate low, and makes the next tick load the ratchet from its knob angle.
`include "haptic_ratchet_torque_macros.svh"

module haptic_ratchet_torque (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // knob_angle, rate_mv, gate_mv, gate_plugged, tick_us, flip_direction
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // drive_torque, ratchet_position, forward, zero padding
  output logic [71:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);
  import hrt_pkg::*;

  hrt_cfg_t           cfg_r;

  logic               s0_valid_r;
  logic signed [31:0] s0_angle_r;
  logic signed [14:0] s0_rate_r;
  logic signed [14:0] s0_gate_r;
  logic               s0_plugged_r;
  logic        [15:0] s0_tick_r;
  logic               s0_flip_r;
  logic               s0_ready;

  logic               dir_fwd;
  logic               creep_in_ready;
  hrt_pre_t           pre_item;
  logic               mid_valid;
  logic               mid_ready;
  hrt_mid_t           mid_item;

  logic signed [31:0] torque;
  logic signed [31:0] position;
  logic               fwd_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate_max_mv       <= 14'd10000;
      cfg_r.gate_threshold_mv <= 15'sd1500;
      cfg_r.gate_half_gap_mv  <= 13'd250;
    end else if (cfg_we) begin
      unique case (hrt_cfg_idx_e'(cfg_index))
        CFG_RATE_MAX: cfg_r.rate_max_mv       <= cfg_wdata[13:0];
        CFG_GATE_THR: cfg_r.gate_threshold_mv <= $signed(cfg_wdata);
        CFG_GATE_GAP: cfg_r.gate_half_gap_mv  <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  assign s0_ready  = !s0_valid_r || creep_in_ready;
  assign in_tready = s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_tvalid) begin
      s0_angle_r   <= $signed(in_tdata[31:0]);
      s0_rate_r    <= $signed(in_tdata[46:32]);
      s0_gate_r    <= $signed(in_tdata[61:47]);
      s0_plugged_r <= in_tdata[62];
      s0_tick_r    <= in_tdata[78:63];
      s0_flip_r    <= in_tdata[79];
    end
  end

  hrt_dir u_dir (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (s0_valid_r && creep_in_ready),
    .cfg            (cfg_r),
    .gate_mv        (s0_gate_r),
    .gate_plugged   (s0_plugged_r),
    .flip_direction (s0_flip_r),
    .forward        (dir_fwd)
  );

  always_comb begin
    pre_item.knob_angle = s0_angle_r;
    pre_item.rate_mv    = s0_rate_r;
    pre_item.tick_us    = s0_tick_r;
    pre_item.forward    = dir_fwd;
  end

  hrt_creep u_creep (
    .clk         (clk),
    .rst_n       (rst_n),
    .rate_max_mv (cfg_r.rate_max_mv),
    .in_valid    (s0_valid_r),
    .in_ready    (creep_in_ready),
    .in_item     (pre_item),
    .out_valid   (mid_valid),
    .out_ready   (mid_ready),
    .out_item    (mid_item)
  );

  hrt_ratchet u_ratchet (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (mid_valid),
    .in_ready     (mid_ready),
    .in_item      (mid_item),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_torque   (torque),
    .out_position (position),
    .out_forward  (fwd_out)
  );

  assign out_tdata = {7'b0, fwd_out, position, torque};

  `HRT_ASSERT_IMP(a_ready_when_drained, clk, rst_n, !out_tvalid, in_tready)
  `HRT_ASSERT_IMP(a_reverse_torque_sign, clk, rst_n, out_tvalid && !out_tdata[64],
    out_tdata[31] || (out_tdata[31:0] == 32'd0))
  `HRT_ASSERT_ALWAYS(a_forward_torque_sign, clk, rst_n,
    !(out_tvalid && out_tdata[64] && out_tdata[31]))

endmodule

// ===== tb/haptic_ratchet_torque_test.sv =====
// Self-checking testbench for the haptic ratchet torque block.
module haptic_ratchet_torque_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hrt_pkg::*;

  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int         DEAD_TURNS     = 1311;
  localparam int         OFFSET_TURNS   = 655;
  localparam int         SPRING_GAIN    = 200;
  localparam int         INT32_MIN      = -2147483648;
  localparam int         INT32_MAX      = 2147483647;

  typedef struct packed {
    logic               flip;
    logic        [15:0] tick_us;
    logic               plugged;
    logic signed [14:0] gate_mv;
    logic signed [14:0] rate_mv;
    logic signed [31:0] knob_angle;
  } tick_req_t;

  typedef struct packed {
    logic        [6:0]  pad;
    logic               fwd;
    logic signed [31:0] position;
    logic signed [31:0] torque;
  } torque_res_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = CFG_RATE_MAX;
  logic [14:0] cfg_wdata  = '0;

  haptic_ratchet_torque dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  int mdl_rate_max = 10000;
  int mdl_thr      = 1500;
  int mdl_gap      = 250;
  int mdl_ratchet  = 0;
  bit mdl_forward  = 1'b1;
  bit mdl_gate_hi  = 1'b0;
  bit mdl_started  = 1'b0;

  torque_res_t pending_results[$];
  int          send_idle_pct = 0;
  int          rx_stall_pct  = 0;
  bit          rx_hold       = 1'b0;
  int          last_angle    = 0;
  int          errors        = 0;
  int          n_ticks       = 0;
  int          n_checked     = 0;
  int          n_torque      = 0;
  int          n_follow      = 0;
  int          n_saturated   = 0;
  int          n_settings    = 1;

  function automatic longint clamp_s32(longint v);
    if (v > INT32_MAX) return INT32_MAX;
    if (v < INT32_MIN) return INT32_MIN;
    return v;
  endfunction

  function automatic torque_res_t predict_ratchet(tick_req_t t);
    torque_res_t res;
    longint      angle, rate, gate_v, hi, lo, r, creep, torque, raw;
    angle  = t.knob_angle;
    rate   = t.rate_mv;
    gate_v = t.gate_mv;
    torque = 0;
    if (!mdl_started) begin
      mdl_ratchet = int'(angle);
      mdl_started = 1'b1;
    end
    if (t.flip) begin
      mdl_forward = !mdl_forward;
    end
    hi = longint'(mdl_thr) + mdl_gap;
    lo = longint'(mdl_thr) - mdl_gap;
    if (!mdl_gate_hi && gate_v > hi) begin
      mdl_gate_hi = 1'b1;
    end else if (mdl_gate_hi && gate_v < lo) begin
      mdl_gate_hi = 1'b0;
    end
    if (t.plugged) begin
      mdl_forward = !mdl_gate_hi;
    end
    if (rate < 0) rate = 0;
    if (rate > mdl_rate_max) rate = mdl_rate_max;
    creep = (rate * longint'(t.tick_us) * 32768) / 1000000000;
    r = mdl_ratchet;
    if (mdl_forward) begin
      if (angle > r) begin
        r = angle;
        n_follow++;
      end else begin
        if (r - angle > DEAD_TURNS) begin
          if (r - creep < INT32_MIN) n_saturated++;
          r = clamp_s32(r - creep);
        end
        if (angle <= r - OFFSET_TURNS) begin
          raw = (r - OFFSET_TURNS - angle) * SPRING_GAIN;
          if (raw > INT32_MAX) n_saturated++;
          torque = clamp_s32(raw);
        end
      end
    end else begin
      if (angle < r) begin
        r = angle;
        n_follow++;
      end else begin
        if (angle - r > DEAD_TURNS) begin
          if (r + creep > INT32_MAX) n_saturated++;
          r = clamp_s32(r + creep);
        end
        if (angle >= r + OFFSET_TURNS) begin
          raw = (r + OFFSET_TURNS - angle) * SPRING_GAIN;
          if (raw < INT32_MIN) n_saturated++;
          torque = clamp_s32(raw);
        end
      end
    end
    mdl_ratchet = int'(r);
    if (torque != 0) n_torque++;
    res          = '0;
    res.torque   = torque[31:0];
    res.position = r[31:0];
    res.fwd      = mdl_forward;
    return res;
  endfunction

  function automatic tick_req_t make_tick(longint angle, int rate, int gate, bit plugged,
                                          int tick, bit flip);
    tick_req_t t;
    t.knob_angle = 32'(clamp_s32(angle));
    t.rate_mv    = 15'(rate);
    t.gate_mv    = 15'(gate);
    t.plugged    = plugged;
    t.tick_us    = 16'(tick);
    t.flip       = flip;
    return t;
  endfunction

  function automatic tick_req_t random_tick();
    int     sel, rate, gate;
    longint angle;
    sel = $urandom_range(99);
    if (sel < 15) begin
      angle = int'($urandom);
    end else if (sel < 60) begin
      angle = longint'(mdl_ratchet) + int'($urandom_range(8000)) - 4000;
    end else begin
      angle = longint'(last_angle) + int'($urandom_range(6000)) - 3000;
    end
    angle = clamp_s32(angle);
    last_angle = int'(angle);
    if ($urandom_range(99) < 20) begin
      rate = int'($urandom_range(24000)) - 12000;
    end else begin
      rate = $urandom_range(12000);
    end
    if ($urandom_range(99) < 50) begin
      gate = mdl_thr + int'($urandom_range(4 * mdl_gap + 200)) - 2 * mdl_gap - 100;
      if (gate > 12000) gate = 12000;
      if (gate < -12000) gate = -12000;
    end else begin
      gate = int'($urandom_range(24000)) - 12000;
    end
    return make_tick(angle, rate, gate, $urandom_range(99) < 30,
                     ($urandom_range(99) < 10) ? $urandom_range(3) : $urandom_range(65535),
                     $urandom_range(99) < 8);
  endfunction

  task automatic send_tick(input tick_req_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_ratchet(t));
    n_ticks++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    go_quiet();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[14:0];
    @(posedge clk);
    case (idx)
      CFG_RATE_MAX: mdl_rate_max = value & 'h3FFF;
      CFG_GATE_THR: mdl_thr = $signed(value[14:0]);
      CFG_GATE_GAP: mdl_gap = value & 'h1FFF;
      default: ;
    endcase
  endtask

  task automatic load_settings(input int rate_max, input int thr, input int gap);
    drain_results();
    write_register(CFG_RATE_MAX, rate_max);
    write_register(CFG_GATE_THR, thr);
    write_register(CFG_GATE_GAP, gap);
    write_register(CFG_UNUSED_IDX, $urandom_range(32767));
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(negedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    torque_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        $display("%0t: result arrived with no tick outstanding", $realtime);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.torque !== want.torque) begin
          report_mismatch("drive_torque", got.torque, want.torque);
        end
        if (got.position !== want.position) begin
          report_mismatch("ratchet_position", got.position, want.position);
        end
        if (got.fwd !== want.fwd) begin
          report_mismatch("forward", got.fwd, want.fwd);
        end
      end
    end
  end

  task automatic test_follow_and_creep();
    send_tick(make_tick(32'sh0001_0000, 0, 0, 1'b0, 1, 1'b0));
    send_tick(make_tick(32'sh0001_8000, 0, 0, 1'b0, 1, 1'b0));
    send_tick(make_tick(mdl_ratchet - 1000, 12000, 0, 1'b0, 65535, 1'b0));
    send_tick(make_tick(mdl_ratchet - 300, 12000, 0, 1'b0, 65535, 1'b0));
    send_tick(make_tick(mdl_ratchet - 20000, 12000, 0, 1'b0, 65535, 1'b0));
    send_tick(make_tick(mdl_ratchet - 20000, -12000, 0, 1'b0, 65535, 1'b0));
    send_tick(make_tick(mdl_ratchet - 20000, 5000, 0, 1'b0, 0, 1'b0));
    send_tick(make_tick(mdl_ratchet - 20000, 9999, 0, 1'b0, 40000, 1'b0));
  endtask

  task automatic test_direction_and_gate();
    send_tick(make_tick(mdl_ratchet - 500, 0, 0, 1'b0, 100, 1'b1));
    send_tick(make_tick(mdl_ratchet + 5000, 8000, 0, 1'b0, 30000, 1'b0));
    send_tick(make_tick(mdl_ratchet + 1000, 8000, 12000, 1'b1, 30000, 1'b0));
    send_tick(make_tick(mdl_ratchet - 3000, 8000, 1600, 1'b1, 30000, 1'b0));
    send_tick(make_tick(mdl_ratchet - 3000, 8000, -12000, 1'b1, 30000, 1'b1));
    send_tick(make_tick(mdl_ratchet - 3000, 8000, 1600, 1'b0, 30000, 1'b1));
    send_tick(make_tick(mdl_ratchet, 8000, 1251, 1'b1, 30000, 1'b1));
  endtask

  task automatic test_saturation();
    if (!mdl_forward) begin
      send_tick(make_tick(mdl_ratchet, 0, -12000, 1'b0, 1, 1'b1));
    end
    send_tick(make_tick(INT32_MAX, 0, -12000, 1'b0, 1, 1'b0));
    send_tick(make_tick(INT32_MIN, 0, -12000, 1'b0, 1, 1'b0));
    send_tick(make_tick(INT32_MIN, 0, -12000, 1'b0, 1, 1'b1));
    send_tick(make_tick(INT32_MAX, 0, -12000, 1'b0, 1, 1'b0));
    send_tick(make_tick(longint'(INT32_MAX) - 2000, 0, -12000, 1'b0, 1, 1'b1));
    send_tick(make_tick(INT32_MAX, 12000, -12000, 1'b0, 65535, 1'b1));
    send_tick(make_tick(longint'(INT32_MIN) + 2000, 0, -12000, 1'b0, 1, 1'b0));
    send_tick(make_tick(INT32_MIN, 12000, -12000, 1'b0, 65535, 1'b1));
  endtask

  task automatic test_register_extremes();
    load_settings(0, -12000, 0);
    repeat (20) send_tick(random_tick());
  endtask

  task automatic test_random_traffic(input int send_pct, input int stall_pct, input int count,
                                     input int rate_max, input int thr, input int gap);
    load_settings(rate_max, thr, gap);
    send_idle_pct = send_pct;
    rx_stall_pct  = stall_pct;
    repeat (count) send_tick(random_tick());
  endtask

  task automatic hold_receiver(input int cycles);
    rx_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold = 1'b0;
  endtask

  task automatic test_back_pressure();
    drain_results();
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    fork
      hold_receiver(120);
      repeat (60) send_tick(random_tick());
    join
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_follow_and_creep();
    test_direction_and_gate();
    test_saturation();
    test_register_extremes();
    test_random_traffic(0, 0, 115, 12000, 12000, 6000);
    test_random_traffic(87, 0, 115, 7000, 0, 6000);
    test_random_traffic(0, 87, 115, $urandom_range(12000),
                        int'($urandom_range(24000)) - 12000, $urandom_range(6000));
    test_random_traffic(34, 34, 115, 10000, 1500, 250);
    test_back_pressure();
    drain_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d ticks and checked %0d results over %0d register settings.",
             n_ticks, n_checked, n_settings);
    $display("Seen: %0d spring torques, %0d follow moves, %0d saturations, %0d mismatches.",
             n_torque, n_follow, n_saturated, errors);
    if (errors == 0) begin
      $display("haptic_ratchet_torque_test: PASS");
    end else begin
      $display("haptic_ratchet_torque_test: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Run timed out with %0d results outstanding.", pending_results.size());
    $display("haptic_ratchet_torque_test: FAIL");
    $finish;
  end

endmodule
